FILE: rtl/imc_pkg.sv
// ----------------------------------------------------------------------------
// imc_pkg: six-axis IMU calibration package
// Shared widths, constants, register codes and the per-axis coefficient
// derivation used by the top level and the lanes.
// ----------------------------------------------------------------------------
package imc_pkg;

  localparam int NAX         = 6;
  localparam int NGYRO       = 3;
  localparam int QW          = 44;        // quotient / dividend magnitude bits
  localparam int PIPE_DEPTH  = QW + 2;    // operand stage + product stage + divide
  localparam int GYRO_UNIT   = 1024;
  localparam int ACCEL_UNIT  = 8192;
  localparam int GYRO_FULL   = 2048 * GYRO_UNIT;
  localparam int ACCEL_FULL  = 4 * ACCEL_UNIT;
  localparam int DEFAULT_DEN = 32767;

  typedef enum logic [2:0] {
    REG_GYRO_PITCH = 3'd0,
    REG_GYRO_YAW   = 3'd1,
    REG_GYRO_ROLL  = 3'd2,
    REG_GYRO_SPEED = 3'd3,
    REG_ACCEL_X    = 3'd4,
    REG_ACCEL_Y    = 3'd5,
    REG_ACCEL_Z    = 3'd6,
    REG_CAL_VALID  = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic signed [17:0] bias;
    logic signed [26:0] numer;
    logic signed [16:0] denom;
  } imc_coef_t;

  typedef struct packed {
    logic [15:0]   rem;
    logic [QW-1:0] work;
    logic [15:0]   dvs;
    logic          neg;
  } imc_div_t;

  function automatic imc_coef_t imc_derive(logic [31:0] pair, logic is_gyro,
                                           logic signed [16:0] speed2);
    imc_coef_t          c;
    logic signed [16:0] d;
    logic signed [16:0] half;
    d    = $signed({pair[31], pair[31:16]}) - $signed({pair[15], pair[15:0]});
    half = (d + $signed({16'd0, d[16]})) >>> 1;   // truncate toward zero
    if (d == 17'sd0) begin
      c.bias  = '0;
      c.numer = is_gyro ? 27'(GYRO_FULL) : 27'(ACCEL_FULL);
      c.denom = 17'(DEFAULT_DEN);
    end else if (is_gyro) begin
      c.bias  = '0;
      c.numer = {speed2, 10'd0};
      c.denom = d;
    end else begin
      c.bias  = $signed({{2{pair[31]}}, pair[31:16]}) - $signed({half[16], half});
      c.numer = 27'(2 * ACCEL_UNIT);
      c.denom = d;
    end
    return c;
  endfunction

endpackage

FILE: rtl/imc_div_stage.sv
// ----------------------------------------------------------------------------
// imc_div_stage: one restoring-division step
// Brings down one dividend bit, trial subtracts the divisor, registers.
// ----------------------------------------------------------------------------
module imc_div_stage import imc_pkg::*; (
  input  logic     clk_i,
  input  imc_div_t st_i,
  output imc_div_t st_o
);

  logic [16:0] trial;
  logic [16:0] diff;
  logic        ge;
  imc_div_t    st_d, st_q;

  always_comb begin
    trial     = {st_i.rem, st_i.work[QW-1]};
    diff      = trial - {1'b0, st_i.dvs};
    ge        = (trial >= {1'b0, st_i.dvs});
    st_d      = st_i;
    st_d.rem  = ge ? diff[15:0] : trial[15:0];
    st_d.work = {st_i.work[QW-2:0], ge};
  end

  always_ff @(posedge clk_i) begin
    st_q <= st_d;
  end

  assign st_o = st_q;

endmodule

FILE: rtl/imc_lane.sv
// ----------------------------------------------------------------------------
// imc_lane: one axis of the calibration datapath
// Offset, multiply, then a QW-step pipelined divide with sign restore.
// ----------------------------------------------------------------------------
module imc_lane import imc_pkg::*; (
  input  logic               clk_i,
  input  logic signed [15:0] raw_i,
  input  imc_coef_t          coef_i,
  output logic        [15:0] cal_o,
  output logic               ovf_o
);

  logic signed [17:0] diff_q;
  logic signed [26:0] numer_q;
  logic signed [16:0] denom_q;
  logic signed [44:0] prod;
  logic        [44:0] pmag;
  logic        [16:0] dmag;
  imc_div_t           st [QW+1];
  imc_div_t           st0_d;
  logic        [44:0] q;

  always_ff @(posedge clk_i) begin
    diff_q  <= $signed({{2{raw_i[15]}}, raw_i}) - coef_i.bias;
    numer_q <= coef_i.numer;
    denom_q <= coef_i.denom;
  end

  always_comb begin
    prod       = 45'(diff_q) * 45'(numer_q);
    pmag       = prod[44] ? 45'(-prod) : prod;
    dmag       = denom_q[16] ? 17'(-denom_q) : denom_q;
    st0_d.rem  = '0;
    st0_d.work = pmag[QW-1:0];
    st0_d.dvs  = dmag[15:0];
    st0_d.neg  = prod[44] ^ denom_q[16];
  end

  always_ff @(posedge clk_i) begin
    st[0] <= st0_d;
  end

  for (genvar i = 0; i < QW; i++) begin : g_div
    imc_div_stage u_stage (
      .clk_i (clk_i),
      .st_i  (st[i]),
      .st_o  (st[i+1])
    );
  end

  always_comb begin
    q     = st[QW].neg ? 45'(-{1'b0, st[QW].work}) : {1'b0, st[QW].work};
    cal_o = q[15:0];
    ovf_o = st[QW].neg ? (st[QW].work > QW'(32768)) : (st[QW].work > QW'(32767));
  end

endmodule

FILE: rtl/six_axis_imu_calibration.sv
// ----------------------------------------------------------------------------
// six_axis_imu_calibration: linear calibration of one gyro + accel frame
// Path from start to done: operand stage, product stage, 44 divide steps,
// output register. Throughput: one item per cycle; busy_o stays low since
// the divide is fully pipelined, one quotient bit per stage, in six lanes.
// Reset clears all calibration registers and the valid pipeline; the result
// side cannot stall, so each result shows for exactly one cycle on done_o.
// ----------------------------------------------------------------------------
module six_axis_imu_calibration import imc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic               cfg_we_i,
  input  logic        [2:0]  cfg_idx_i,
  input  logic        [31:0] cfg_wdata_i,
  input  logic signed [15:0] pitch_raw_i,
  input  logic signed [15:0] yaw_raw_i,
  input  logic signed [15:0] roll_raw_i,
  input  logic signed [15:0] ax_raw_i,
  input  logic signed [15:0] ay_raw_i,
  input  logic signed [15:0] az_raw_i,
  output logic               done_o,
  output logic signed [15:0] pitch_cal_o,
  output logic signed [15:0] yaw_cal_o,
  output logic signed [15:0] roll_cal_o,
  output logic signed [15:0] ax_cal_o,
  output logic signed [15:0] ay_cal_o,
  output logic signed [15:0] az_cal_o,
  output logic        [5:0]  overflow_flags_o
);

  // Calibration pairs: plus reading high half, minus reading low half.
  logic [31:0] pitch_q, yaw_q, roll_q, speed_q, axp_q, ayp_q, azp_q;
  logic        cal_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pitch_q     <= '0;
      yaw_q       <= '0;
      roll_q      <= '0;
      speed_q     <= '0;
      axp_q       <= '0;
      ayp_q       <= '0;
      azp_q       <= '0;
      cal_valid_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_GYRO_PITCH: pitch_q     <= cfg_wdata_i;
        REG_GYRO_YAW:   yaw_q       <= cfg_wdata_i;
        REG_GYRO_ROLL:  roll_q      <= cfg_wdata_i;
        REG_GYRO_SPEED: speed_q     <= cfg_wdata_i;
        REG_ACCEL_X:    axp_q       <= cfg_wdata_i;
        REG_ACCEL_Y:    ayp_q       <= cfg_wdata_i;
        REG_ACCEL_Z:    azp_q       <= cfg_wdata_i;
        REG_CAL_VALID:  cal_valid_q <= cfg_wdata_i[0];
        default:        ;
      endcase
    end
  end

  // Coefficients depend on config only; the user must keep config static while items flow (not enforced here).
  logic signed [16:0] speed2;
  imc_coef_t          coef [NAX];
  logic signed [15:0] raw  [NAX];
  logic        [15:0] cal  [NAX];
  logic        [NAX-1:0] ovf;

  always_comb begin
    speed2  = $signed({speed_q[31], speed_q[31:16]}) + $signed({speed_q[15], speed_q[15:0]});
    coef[0] = imc_derive(pitch_q, 1'b1, speed2);
    coef[1] = imc_derive(yaw_q,   1'b1, speed2);
    coef[2] = imc_derive(roll_q,  1'b1, speed2);
    coef[3] = imc_derive(axp_q,   1'b0, speed2);
    coef[4] = imc_derive(ayp_q,   1'b0, speed2);
    coef[5] = imc_derive(azp_q,   1'b0, speed2);
    raw[0]  = pitch_raw_i;
    raw[1]  = yaw_raw_i;
    raw[2]  = roll_raw_i;
    raw[3]  = ax_raw_i;
    raw[4]  = ay_raw_i;
    raw[5]  = az_raw_i;
  end

  for (genvar a = 0; a < NAX; a++) begin : g_lane
    imc_lane u_lane (
      .clk_i  (clk_i),
      .raw_i  (raw[a]),
      .coef_i (coef[a]),
      .cal_o  (cal[a]),
      .ovf_o  (ovf[a])
    );
  end

  // Always ready; frames are dropped while calibration is not valid.
  assign busy_o = 1'b0;

  logic [PIPE_DEPTH-1:0] vld_q, vld_d;
  logic                  done_q;

  assign vld_d = {vld_q[PIPE_DEPTH-2:0], start_i & cal_valid_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      done_q <= 1'b0;
    end else begin
      vld_q  <= vld_d;
      done_q <= vld_q[PIPE_DEPTH-1];
    end
  end

  // Merge: gather all lanes into the output register.
  logic [15:0] cal_q [NAX];
  logic [5:0]  flags_q;

  always_ff @(posedge clk_i) begin
    if (vld_q[PIPE_DEPTH-1]) begin
      for (int k = 0; k < NAX; k++) begin
        cal_q[k] <= cal[k];
      end
      flags_q <= ovf;
    end
  end

  assign done_o           = done_q;
  assign pitch_cal_o      = cal_q[0];
  assign yaw_cal_o        = cal_q[1];
  assign roll_cal_o       = cal_q[2];
  assign ax_cal_o         = cal_q[3];
  assign ay_cal_o         = cal_q[4];
  assign az_cal_o         = cal_q[5];
  assign overflow_flags_o = flags_q;

endmodule

FILE: tb/imc_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// imc_checker: calibrated-frame scoreboard
// Mirrors the calibration registers, predicts each accepted item's calibrated
// frame and compares it field by field with what the block reports on done.
// ----------------------------------------------------------------------------
module imc_checker import imc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_i,
  input  logic               cfg_we_i,
  input  logic        [2:0]  cfg_idx_i,
  input  logic        [31:0] cfg_wdata_i,
  input  logic signed [15:0] raw_i [NAX],
  input  logic               done_i,
  input  logic signed [15:0] cal_i [NAX],
  input  logic        [5:0]  ovf_i,
  output int                 fail_cnt_o,
  output int                 pending_o
);

  typedef struct {
    logic [15:0] cal [NAX];
    logic [5:0]  ovf;
  } frame_t;

  logic [31:0] cal_regs [8];
  frame_t      frames_q [$];

  function automatic logic signed [31:0] half_sext(logic [15:0] h);
    return 32'(signed'(h));
  endfunction

  function automatic frame_t calibrate(logic signed [15:0] raw [NAX]);
    frame_t      f;
    logic [31:0] pr;
    longint      plus, d, bias, numer, denom, q, speed2;
    speed2 = half_sext(cal_regs[REG_GYRO_SPEED][31:16]) +
             half_sext(cal_regs[REG_GYRO_SPEED][15:0]);
    f.ovf = '0;
    for (int i = 0; i < NAX; i++) begin
      pr    = (i < NGYRO) ? cal_regs[i] : cal_regs[i + 1];
      plus  = half_sext(pr[31:16]);
      d     = plus - half_sext(pr[15:0]);
      if (d == 0) begin
        bias  = 0;
        numer = (i < NGYRO) ? GYRO_FULL : ACCEL_FULL;
        denom = DEFAULT_DEN;
      end else if (i < NGYRO) begin
        bias  = 0;
        numer = speed2 * GYRO_UNIT;
        denom = d;
      end else begin
        bias  = plus - d / 2;   // SV division truncates toward zero
        numer = 2 * ACCEL_UNIT;
        denom = d;
      end
      q = ((longint'(raw[i]) - bias) * numer) / denom;
      f.cal[i] = q[15:0];
      f.ovf[i] = (q < -32768 || q > 32767);
    end
    return f;
  endfunction

  assign pending_o = frames_q.size();

  always_ff @(posedge clk_i or negedge rst_ni) begin
    frame_t exp_f;
    logic   bad;
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) cal_regs[i] <= '0;
      fail_cnt_o <= 0;
    end else begin
      if (done_i) begin
        if (frames_q.size() == 0) begin
          fail_cnt_o <= fail_cnt_o + 1;
          if (fail_cnt_o < 10) $display("unexpected result frame at %0t", $realtime);
        end else begin
          exp_f = frames_q.pop_front();
          bad   = (exp_f.ovf !== ovf_i);
          for (int i = 0; i < NAX; i++) if (exp_f.cal[i] !== cal_i[i]) bad = 1;
          if (bad) begin
            fail_cnt_o <= fail_cnt_o + 1;
            if (fail_cnt_o < 10)
              $display("frame mismatch exp %h %h %h %h %h %h ovf %b got %h %h %h %h %h %h ovf %b",
                       exp_f.cal[0], exp_f.cal[1], exp_f.cal[2], exp_f.cal[3],
                       exp_f.cal[4], exp_f.cal[5], exp_f.ovf, cal_i[0], cal_i[1],
                       cal_i[2], cal_i[3], cal_i[4], cal_i[5], ovf_i);
          end
        end
      end
      // valid bit gates the prediction; frames are dropped when it is clear
      if (start_i && !busy_i && cal_regs[REG_CAL_VALID][0])
        frames_q.push_back(calibrate(raw_i));
      if (cfg_we_i)
        cal_regs[cfg_idx_i] <= (cfg_idx_i == REG_CAL_VALID) ? {31'd0, cfg_wdata_i[0]}
                                                            : cfg_wdata_i;
    end
  end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: six-axis IMU calibration testbench
// Drives frames and calibration writes under several idling phases; the
// checker predicts every calibrated frame and counts mismatches.
// ----------------------------------------------------------------------------
module tb_top;
  import imc_pkg::*;

  localparam int LATENCY   = 47;
  localparam int WDOG_MAX  = 2000;

  logic               clk_i = 0;
  logic               rst_ni = 0;
  logic               start_i = 0;
  logic               busy_o;
  logic               cfg_we_i = 0;
  logic        [2:0]  cfg_idx_i = '0;
  logic        [31:0] cfg_wdata_i = '0;
  logic signed [15:0] raw [NAX];
  logic               done_o;
  logic signed [15:0] cal [NAX];
  logic        [5:0]  overflow_flags_o;
  int                 fail_cnt, pending, idle_cycles;

  initial for (int i = 0; i < NAX; i++) raw[i] = '0;

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  six_axis_imu_calibration dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .pitch_raw_i(raw[0]), .yaw_raw_i(raw[1]), .roll_raw_i(raw[2]),
    .ax_raw_i(raw[3]), .ay_raw_i(raw[4]), .az_raw_i(raw[5]),
    .done_o,
    .pitch_cal_o(cal[0]), .yaw_cal_o(cal[1]), .roll_cal_o(cal[2]),
    .ax_cal_o(cal[3]), .ay_cal_o(cal[4]), .az_cal_o(cal[5]),
    .overflow_flags_o
  );

  imc_checker u_chk (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .raw_i(raw), .done_i(done_o), .cal_i(cal), .ovf_i(overflow_flags_o),
    .fail_cnt_o(fail_cnt), .pending_o(pending)
  );

  // Watchdog: cycles without an accepted item, result or register write.
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o || cfg_we_i) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WDOG_MAX) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end
  initial idle_cycles = 0;

  task automatic write_reg(input cfg_reg_e idx, input logic [31:0] val);
    cfg_we_i    <= 1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i    <= 0;
  endtask

  // Wait until every expected frame is back, then let the pipe drain
  // (dropped frames give no result but may still be in flight).
  task automatic drain();
    while (pending != 0) @(negedge clk_i);
    repeat (LATENCY + 3) @(negedge clk_i);
  endtask

  // Send one frame; idle_pct is the chance of a gap cycle before it.
  // start_i stays high between back-to-back items.
  task automatic send_frame(input logic [15:0] v [NAX], input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 0;
      @(negedge clk_i);
    end
    start_i <= 1;
    for (int i = 0; i < NAX; i++) raw[i] <= v[i];
    @(negedge clk_i);
    while (busy_o) @(negedge clk_i);
  endtask

  task automatic end_burst();
    start_i <= 0;
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] rand_pair(int style);
    logic [15:0] p, m;
    p = 16'($urandom);
    m = 16'($urandom);
    case (style)
      0: m = p;                                   // zero span: default scale
      1: m = p - 16'($urandom_range(1, 4));       // tiny span: overflow
      2: begin p = 16'sd16384; m = -16'sd16384; end  // realistic
      default: ;
    endcase
    return {p, m};
  endfunction

  task automatic random_setup(input bit valid);
    for (int r = 0; r < 7; r++) write_reg(cfg_reg_e'(r), rand_pair($urandom_range(4)));
    write_reg(REG_CAL_VALID, {27'd0, 4'($urandom_range(15)), valid});
  endtask

  logic [15:0] fr [NAX];
  logic [15:0] corner [6] = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h0001, 16'h5555};
  int          idle_pct;

  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    // Frames while calibration is not valid are dropped.
    for (int i = 0; i < NAX; i++) fr[i] = 16'($urandom);
    send_frame(fr, 0);
    send_frame(fr, 0);
    end_burst();

    // Zero-span pairs: default scale on every axis.
    write_reg(REG_CAL_VALID, 32'hffff_ffff);
    for (int k = 0; k < 6; k++) begin
      for (int i = 0; i < NAX; i++) fr[i] = corner[(k + i) % 6];
      send_frame(fr, 0);
    end
    end_burst();
    drain();

    // Extreme pairs: negative and maximal spans, wrap and overflow.
    write_reg(REG_GYRO_PITCH, 32'h7fff_8000);
    write_reg(REG_GYRO_YAW,   32'h8000_7fff);   // negative denominator
    write_reg(REG_GYRO_ROLL,  32'h0001_0000);   // span one: overflow
    write_reg(REG_GYRO_SPEED, 32'h7fff_7fff);
    write_reg(REG_ACCEL_X,    32'h7fff_8000);
    write_reg(REG_ACCEL_Y,    32'h8000_0001);   // odd negative span
    write_reg(REG_ACCEL_Z,    32'h0000_ffff);
    for (int k = 0; k < 6; k++) begin
      for (int i = 0; i < NAX; i++) fr[i] = corner[(k + 2 * i) % 6];
      send_frame(fr, 0);
    end
    end_burst();
    drain();
    write_reg(REG_GYRO_SPEED, 32'h8000_8000);
    for (int k = 0; k < 4; k++) begin
      for (int i = 0; i < NAX; i++) fr[i] = corner[(k + i) % 6];
      send_frame(fr, 0);
    end
    end_burst();
    drain();

    // Random phases: no idling, heavy sender idling, moderate idling.
    for (int ph = 0; ph < 9; ph++) begin
      random_setup(ph != 4);
      case (ph % 3)
        0: idle_pct = 0;
        1: idle_pct = 88;
        default: idle_pct = 34;
      endcase
      for (int n = 0; n < 50; n++) begin
        for (int i = 0; i < NAX; i++)
          fr[i] = ($urandom_range(3) == 0) ? corner[$urandom_range(5)] : 16'($urandom);
        send_frame(fr, idle_pct);
        if ($urandom_range(9) == 0) end_burst();
      end
      end_burst();
      drain();
    end

    if (fail_cnt == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
